/* sv/cms_pkg.sv */
// ----------------------------------------------------------------------------
// cms_pkg
// shared types and constants of the count-min sketch counter
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int unsigned NUM_ROWS    = 7;
    localparam int unsigned KEY_W       = 32;
    localparam int unsigned EST_W       = 32;
    localparam int unsigned CNT_W       = 32;     // counter width, 8 to 64
    localparam int unsigned ADDR_W      = 12;     // enough for the largest prime
    localparam int unsigned MEM_DEPTH   = 2719;   // largest row prime
    localparam int unsigned CFG_DATA_W  = 32;

    // exact reciprocal division: q = (key * m) >> (key bits + ceil(log2 p))
    localparam int unsigned RECIP_SHIFT = KEY_W + ADDR_W;
    localparam int unsigned RECIP_W     = KEY_W + 1;
    localparam int unsigned QUOT_W      = KEY_W - ADDR_W + 1;
    localparam int unsigned PROD_W      = KEY_W + RECIP_W;

    // row 0 sits in the low slice
    localparam logic [NUM_ROWS-1:0][ADDR_W-1:0] ROW_PRIME = {
        12'd2689, 12'd2693, 12'd2699, 12'd2707, 12'd2711, 12'd2713, 12'd2719
    };

    localparam logic [PROD_W-1:0] RECIP_NUM = PROD_W'(1) << RECIP_SHIFT;

    localparam logic [NUM_ROWS-1:0][RECIP_W-1:0] RECIP = {
        RECIP_W'((RECIP_NUM + PROD_W'(ROW_PRIME[6]) - PROD_W'(1)) / PROD_W'(ROW_PRIME[6])),
        RECIP_W'((RECIP_NUM + PROD_W'(ROW_PRIME[5]) - PROD_W'(1)) / PROD_W'(ROW_PRIME[5])),
        RECIP_W'((RECIP_NUM + PROD_W'(ROW_PRIME[4]) - PROD_W'(1)) / PROD_W'(ROW_PRIME[4])),
        RECIP_W'((RECIP_NUM + PROD_W'(ROW_PRIME[3]) - PROD_W'(1)) / PROD_W'(ROW_PRIME[3])),
        RECIP_W'((RECIP_NUM + PROD_W'(ROW_PRIME[2]) - PROD_W'(1)) / PROD_W'(ROW_PRIME[2])),
        RECIP_W'((RECIP_NUM + PROD_W'(ROW_PRIME[1]) - PROD_W'(1)) / PROD_W'(ROW_PRIME[1])),
        RECIP_W'((RECIP_NUM + PROD_W'(ROW_PRIME[0]) - PROD_W'(1)) / PROD_W'(ROW_PRIME[0]))
    };

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;

    typedef enum logic {
        ACT_ADD = 1'b0,
        ACT_EST = 1'b1
    } t_action;

    typedef enum logic {
        REG_ENABLE   = 1'b0,
        REG_STOP_THR = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_action          action;
        logic [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic [EST_W-1:0] estimate;
        logic             counted;
        logic             stopped;
    } t_out_item;

    typedef struct packed {
        t_action                   action;
        logic [NUM_ROWS-1:0][ADDR_W-1:0] addr;
    } t_job;

    typedef struct packed {
        logic             enable;
        logic [EST_W-1:0] stop_thr;
    } t_cfg;

endpackage

/* sv/cms_front.sv */
// ----------------------------------------------------------------------------
// cms_front
// accepts transactions and turns the key into one cell address per row
// ----------------------------------------------------------------------------
module cms_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cms_pkg::t_in_item i_in_item,
    input  logic              i_clr_done,
    input  logic              i_q_full,
    output logic              o_push,
    output cms_pkg::t_job     o_job
);
    import cms_pkg::*;

    logic                               r_s1_v;
    t_action                            r_s1_action;
    logic [KEY_W-1:0]                   r_s1_key;
    logic [NUM_ROWS-1:0][QUOT_W-1:0]    r_s1_q;
    logic                               r_s2_v;
    t_job                               r_s2_job;

    logic [NUM_ROWS-1:0][PROD_W-1:0]    prod;
    logic [NUM_ROWS-1:0][QUOT_W-1:0]    quot;
    logic [NUM_ROWS-1:0][KEY_W-1:0]     diff;
    logic [NUM_ROWS-1:0][ADDR_W-1:0]    rem;
    logic                               accept;
    logic                               s2_free;
    logic                               s1_move;

    // quotient by reciprocal multiply, then remainder by multiply-subtract
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            prod[r] = PROD_W'(i_in_item.key) * PROD_W'(RECIP[r]);
            quot[r] = prod[r][RECIP_SHIFT +: QUOT_W];
            diff[r] = r_s1_key - KEY_W'(KEY_W'(r_s1_q[r]) * KEY_W'(ROW_PRIME[r]));
            rem[r]  = diff[r][ADDR_W-1:0];
        end
    end

    assign o_push     = r_s2_v && !i_q_full;
    assign s2_free    = !r_s2_v || o_push;
    assign s1_move    = r_s1_v && s2_free;
    assign o_in_ready = i_clr_done && (!r_s1_v || s2_free);
    assign accept     = i_in_valid && o_in_ready;
    assign o_job      = r_s2_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_s2_v <= 1'b1;
            end else if (o_push) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_action <= i_in_item.action;
            r_s1_key    <= i_in_item.key;
            r_s1_q      <= quot;
        end
        if (s1_move) begin
            r_s2_job.action <= r_s1_action;
            r_s2_job.addr   <= rem;
        end
    end

endmodule

/* sv/cms_queue.sv */
// ----------------------------------------------------------------------------
// cms_queue
// two-entry queue of address jobs between front and back
// ----------------------------------------------------------------------------
module cms_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cms_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output cms_pkg::t_job o_job,
    output logic          o_empty
);
    import cms_pkg::*;

    t_job       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* sv/cms_back.sv */
// ----------------------------------------------------------------------------
// cms_back
// row memories, read-modify-write of the counters, minimum and halt logic
// ----------------------------------------------------------------------------
module cms_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cms_pkg::t_cfg      i_cfg,
    input  cms_pkg::t_job      i_job,
    input  logic               i_job_valid,
    output logic               o_job_pop,
    output logic               o_clr_done,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cms_pkg::t_out_item o_out_item
);
    import cms_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_MIN,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic                            r_clr_done;
    t_addr                           r_clr_cnt;
    logic                            r_halted;
    logic                            r_out_v;
    t_out_item                       r_out;
    t_action                         r_action;
    logic [NUM_ROWS-1:0][ADDR_W-1:0] r_addr;
    logic                            r_counted;
    logic [NUM_ROWS-1:0][CNT_W-1:0]  r_val;
    t_count                          r_min;

    logic [NUM_ROWS-1:0][CNT_W-1:0]  rdata;
    logic [NUM_ROWS-1:0][CNT_W-1:0]  new_val;
    logic                            counted;
    logic                            mem_we;
    t_addr [NUM_ROWS-1:0]            waddr;
    logic [NUM_ROWS-1:0][CNT_W-1:0]  wdata;
    t_count                          min_val;
    logic [EST_W-1:0]                est;
    logic                            over;
    logic                            out_free;

    function automatic t_count min2(input t_count a, input t_count b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [EST_W-1:0] sat_est(input t_count v);
        return (65'(v) > 65'({EST_W{1'b1}})) ? {EST_W{1'b1}} : EST_W'(v);
    endfunction

    assign counted  = (r_action == ACT_ADD) && i_cfg.enable && !r_halted;
    assign mem_we   = !r_clr_done || ((r_state == S_RMW) && counted);
    assign o_job_pop = (r_state == S_IDLE) && r_clr_done && i_job_valid;
    assign out_free = !r_out_v || i_out_ready;
    assign est      = sat_est(r_min);
    assign over     = r_counted && (est > i_cfg.stop_thr);

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            new_val[r] = (counted && (rdata[r] != {CNT_W{1'b1}})) ?
                         rdata[r] + t_count'(1) : rdata[r];
            waddr[r]   = r_clr_done ? r_addr[r] : r_clr_cnt;
            wdata[r]   = r_clr_done ? new_val[r] : '0;
        end
    end

    // three-level tree over the seven updated counters
    assign min_val = min2(min2(min2(r_val[0], r_val[1]), min2(r_val[2], r_val[3])),
                          min2(min2(r_val[4], r_val[5]), r_val[6]));

    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
        t_count mem [MEM_DEPTH];
        t_count r_rdata;

        always_ff @(posedge i_clk) begin
            if (mem_we) begin
                mem[waddr[r]] <= wdata[r];
            end
            r_rdata <= mem[i_job.addr[r]];
        end

        assign rdata[r] = r_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clr_done <= 1'b0;
            r_clr_cnt  <= '0;
            r_halted   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (!r_clr_done) begin
                r_clr_cnt <= r_clr_cnt + t_addr'(1);
                if (r_clr_cnt == t_addr'(MEM_DEPTH - 1)) begin
                    r_clr_done <= 1'b1;
                end
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_job_pop) begin
                        r_state <= S_RMW;
                    end
                end
                S_RMW: begin
                    r_state <= S_MIN;
                end
                S_MIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state  <= S_IDLE;
                        r_halted <= r_halted || over;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end

        // payload, no reset
        if (o_job_pop) begin
            r_action <= i_job.action;
            r_addr   <= i_job.addr;
        end
        if (r_state == S_RMW) begin
            r_val     <= new_val;
            r_counted <= counted;
        end
        if (r_state == S_MIN) begin
            r_min <= min_val;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out.estimate <= est;
            r_out.counted  <= r_counted;
            r_out.stopped  <= r_halted || over;
        end
    end

    assign o_clr_done  = r_clr_done;
    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    a_rmw_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> r_clr_done)
        else $error("counter update during clearing pass");

    a_over_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.counted && (r_out.estimate > i_cfg.stop_thr)) |-> r_out.stopped)
        else $error("estimate over threshold without stop");

endmodule

/* sv/count_min_sketch_counter.sv */
// ----------------------------------------------------------------------------
// count_min_sketch_counter
// count-min sketch over seven rows of saturating counters with stop threshold
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------------
//  in        input      i_in_valid / o_in_ready   i_in_item  (action, key)
//  out       output     o_out_valid / i_out_ready o_out_item (estimate, counted,
//                                                             stopped)
//  cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  - one result per input transaction, in order
//  - the back end handles one transaction at a time (pop and read, update and
//    write back, minimum tree, threshold check) and pops no new job until the
//    result of the last one is registered; a transaction passes the front's
//    divide stages s1 and s2, any queue wait and then these back-end steps
//  - after reset a clearing pass zeroes all 2719 words of each row memory, during
//    which o_in_ready stays low; configuration writes are taken at any time
//  - either side may stall: the two-entry queue decouples front from back, and
//    the output register holds a result until it is taken
//
module count_min_sketch_counter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input transactions
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  cms_pkg::t_in_item               i_in_item,
    // result transactions
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output cms_pkg::t_out_item              o_out_item,
    // configuration writes
    input  logic                            i_cfg_we,
    input  cms_pkg::t_reg_idx               i_cfg_idx,
    input  logic [cms_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cms_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    // front to queue
    logic q_push;
    t_job front_job;
    logic q_full;

    // queue to back
    logic q_pop;
    t_job head_job;
    logic q_empty;

    // memory clearing status from the back end
    logic clr_done;

    // register writes, reset values match the sketch's power-up state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable   <= 1'b0;
            r_cfg.stop_thr <= 32'hFFFF_FFFE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ENABLE:   r_cfg.enable   <= i_cfg_data[0];
                REG_STOP_THR: r_cfg.stop_thr <= i_cfg_data[EST_W-1:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // front: accept and compute key mod prime for every row
    cms_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_clr_done (clr_done),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (front_job)
    );

    // short queue of address jobs
    cms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    // back: counter memories, update, minimum and stop logic
    cms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (head_job),
        .i_job_valid (!q_empty),
        .o_job_pop   (q_pop),
        .o_clr_done  (clr_done),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

/* tb/tb_count_min_sketch_counter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_count_min_sketch_counter
// self-checking bench for the count-min sketch counter: a local sketch model
// predicts every result, random keys drawn from a small pool pile up counts,
// and a final phase drives the sketch into its halted state
// ----------------------------------------------------------------------------
module tb_count_min_sketch_counter;

    import cms_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 20;      // well past the accept-to-result latency
    localparam int HOLD_CYCLES    = 400;     // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 20000;   // covers the clearing pass after reset
    localparam int POOL_SIZE      = 12;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_vld = 1'b0;
    logic                  o_in_ready;
    t_in_item              in_item = '0;
    logic                  o_out_valid;
    logic                  out_rdy = 1'b0;
    t_out_item             o_out_item;
    logic                  cfg_we = 1'b0;
    t_reg_idx              cfg_idx = REG_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always #(CLK_HALF) i_clk = ~i_clk;

    count_min_sketch_counter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_vld),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_rdy),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // local sketch: its own counters, halt flag and register copies
    // ------------------------------------------------------------------------
    t_count           sk_cnt [0:NUM_ROWS-1][0:MEM_DEPTH-1];
    logic             sk_enable;
    logic [EST_W-1:0] sk_thr;
    logic             sk_halted;

    // pending input transactions and the results they must produce
    t_in_item  pending_q [$];
    t_out_item expected_q [$];

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    // traffic shaping, set by the sequence, read by the drivers
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    int          hold_reqs = 0;
    int          hold_served = 0;
    int          hold_left = 0;

    // bookkeeping
    logic in_took = 1'b0;
    int   in_acc = 0;
    int   out_acc = 0;
    int   n_fail = 0;
    int   n_counted = 0;
    int   n_queries = 0;
    int   n_stopped = 0;
    int   idle_cycles = 0;

    // prime modulus of each row
    function automatic int unsigned row_mod(int r);
        case (r)
            0:       return 2719;
            1:       return 2713;
            2:       return 2711;
            3:       return 2707;
            4:       return 2699;
            5:       return 2693;
            default: return 2689;
        endcase
    endfunction

    // minimum over the seven addressed counters, clipped to the estimate width
    function automatic logic [EST_W-1:0] sketch_min(logic [KEY_W-1:0] key);
        t_count low;
        low = '1;
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (sk_cnt[r][key % row_mod(r)] < low) begin
                low = sk_cnt[r][key % row_mod(r)];
            end
        end
        if (CNT_W > EST_W && low > t_count'({EST_W{1'b1}})) begin
            return '1;
        end
        return EST_W'(low);
    endfunction

    // apply one transaction to the local sketch and return its result
    function automatic t_out_item sketch_step(t_in_item it);
        t_out_item res;
        logic      bump;
        int unsigned col;
        bump = (it.action == ACT_ADD) && sk_enable && !sk_halted;
        if (bump) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                col = it.key % row_mod(r);
                // saturate at all ones instead of wrapping
                if (sk_cnt[r][col] != '1) begin
                    sk_cnt[r][col] = sk_cnt[r][col] + 1'b1;
                end
            end
        end
        res.estimate = sketch_min(it.key);
        // threshold only checked after an add that really counted
        if (bump && res.estimate > sk_thr) begin
            sk_halted = 1'b1;
        end
        res.counted = bump;
        res.stopped = sk_halted;
        return res;
    endfunction

    // key mix: pool keys build up counts, row-collision keys share a column
    // in one row, plus field extremes and fully random keys
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 45) begin
            return key_pool[$urandom_range(POOL_SIZE-1)];
        end else if (sel < 60) begin
            return key_pool[$urandom_range(POOL_SIZE-1)]
                   + row_mod($urandom_range(NUM_ROWS-1)) * $urandom_range(8, 1);
        end else if (sel < 70) begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return '1;
                2:       return KEY_W'(1) << $urandom_range(KEY_W-1);
                default: return ~(KEY_W'(1) << $urandom_range(KEY_W-1));
            endcase
        end
        return $urandom();
    endfunction

    task automatic queue_item(t_action act, logic [KEY_W-1:0] key);
        t_in_item it;
        it.action = act;
        it.key    = key;
        pending_q.push_back(it);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) begin
            queue_item(($urandom_range(99) < 70) ? ACT_ADD : ACT_EST, pick_key());
        end
    endtask

    task automatic set_idle(int unsigned src_pct, int unsigned snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    // sender pause: everything sent, taken and answered, then some slack
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_q.size() != 0 || (in_vld && !in_took) || expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic wait_accepted(int target);
        while (in_acc < target) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    // register write on the plain write port, mirrored into the local copy
    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we   = 1'b0;
        case (idx)
            REG_ENABLE:   sk_enable = val[0];
            REG_STOP_THR: sk_thr = val[EST_W-1:0];
            default:      ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // input driver: next pending transaction once the current one is taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : item_driver
        if (!i_rst_n) begin
            in_vld <= 1'b0;
        end else if (!in_vld || in_took) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                in_item <= pending_q.pop_front();
                in_vld  <= 1'b1;
            end else begin
                in_vld <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: random stalls plus the requested long hold-off,
    // counted here so the sender keeps offering transactions meanwhile
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : result_receiver
        if (hold_served != hold_reqs) begin
            hold_served = hold_reqs;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_rdy <= 1'b0;
        end else begin
            out_rdy <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predict on every accepted input, check every accepted result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        in_took = 1'b0;
        if (i_rst_n) begin
            if (in_vld && o_in_ready) begin
                in_took = 1'b1;
                in_acc  = in_acc + 1;
                if (in_item.action == ACT_EST) begin
                    n_queries = n_queries + 1;
                end
                expected_q.push_back(sketch_step(in_item));
            end
            if (o_out_valid && out_rdy) begin
                out_acc = out_acc + 1;
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected: estimate %0d counted %0b stopped %0b",
                           o_out_item.estimate, o_out_item.counted, o_out_item.stopped);
                    n_fail = n_fail + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.counted) begin
                        n_counted = n_counted + 1;
                    end
                    if (want.stopped) begin
                        n_stopped = n_stopped + 1;
                    end
                    if (o_out_item.estimate !== want.estimate) begin
                        $error("estimate: expected %0d, actual %0d",
                               want.estimate, o_out_item.estimate);
                        n_fail = n_fail + 1;
                    end
                    if (o_out_item.counted !== want.counted) begin
                        $error("counted: expected %0b, actual %0b",
                               want.counted, o_out_item.counted);
                        n_fail = n_fail + 1;
                    end
                    if (o_out_item.stopped !== want.stopped) begin
                        $error("stopped: expected %0b, actual %0b",
                               want.stopped, o_out_item.stopped);
                        n_fail = n_fail + 1;
                    end
                end
            end
        end
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge i_clk) begin : watchdog
        if ((in_vld && o_in_ready) || (o_out_valid && out_rdy)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d results outstanding",
                     idle_cycles, expected_q.size());
            $display("count_min_sketch_counter test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin : sequence_main
        int base;
        logic [KEY_W-1:0] hot_key;

        // local sketch matches the cleared state after reset
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < MEM_DEPTH; c++) begin
                sk_cnt[r][c] = '0;
            end
        end
        sk_enable = 1'b0;
        sk_thr    = 32'hFFFF_FFFE;
        sk_halted = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom();
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: adds while disabled are ignored but still answered
        set_idle(0, 0);
        queue_item(ACT_ADD, 32'h0000_0000);
        queue_item(ACT_EST, 32'hFFFF_FFFF);
        queue_item(ACT_ADD, 32'hFFFF_FFFF);
        wait_idle();

        // directed: counting, row collisions, field extremes, max threshold
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_STOP_THR, 32'hFFFF_FFFF);
        queue_item(ACT_ADD, 32'h0000_0000);
        queue_item(ACT_ADD, 32'h0000_0000);
        queue_item(ACT_EST, 32'h0000_0000);
        queue_item(ACT_ADD, 32'hFFFF_FFFF);
        queue_item(ACT_ADD, 32'd2719);              // shares row 0 column with key 0
        queue_item(ACT_EST, 32'd2719);
        queue_item(ACT_EST, 32'd5438);              // row 0 hit, other rows empty
        queue_item(ACT_ADD, 32'h8000_0000);
        queue_item(ACT_ADD, 32'h7FFF_FFFF);
        queue_item(ACT_ADD, 32'hAAAA_AAAA);
        queue_item(ACT_EST, 32'h5555_5555);
        queue_item(ACT_ADD, 32'd18931);
        queue_item(ACT_ADD, 32'd2689 * 32'd2719);   // collides in rows 0 and 6
        queue_item(ACT_EST, 32'd2689 * 32'd2719);
        wait_idle();

        // directed: disable again, then back on with the reset threshold
        write_reg(REG_ENABLE, 32'd0);
        queue_item(ACT_ADD, 32'h0000_0000);
        queue_item(ACT_EST, 32'h0000_0000);
        wait_idle();
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_STOP_THR, 32'hFFFF_FFFE);
        queue_item(ACT_ADD, 32'h0000_0000);
        queue_item(ACT_EST, 32'h0000_0000);
        wait_idle();

        // random, no idling, with a long receiver hold-off partway in
        write_reg(REG_STOP_THR, 32'hFFFF_FFFF);
        base = in_acc;
        queue_random(300);
        wait_accepted(base + 80);
        hold_reqs = hold_reqs + 1;
        wait_idle();

        // random, sender idle, paused midway until all results are back
        set_idle(47, 0);
        write_reg(REG_STOP_THR, 32'h0001_0000);
        queue_random(150);
        wait_idle();
        queue_random(150);
        wait_idle();

        // random, receiver stalling; a stretch with counting disabled first
        set_idle(0, 47);
        write_reg(REG_ENABLE, 32'd0);
        queue_random(60);
        wait_idle();
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_STOP_THR, 32'hFFFF_FFFE);
        queue_random(240);
        wait_idle();

        // random, both sides idling
        set_idle(18, 18);
        write_reg(REG_STOP_THR, $urandom_range(32'hFFFF_FFFF, 32'h0010_0000));
        queue_random(300);
        wait_idle();

        // threshold just above a hot key: hammering it must halt counting
        set_idle(0, 0);
        hot_key = key_pool[0];
        write_reg(REG_STOP_THR, 32'(sketch_min(hot_key)) + 32'd12);
        for (int i = 0; i < 20; i++) begin
            queue_item(ACT_ADD, hot_key);
            queue_random(1);
        end
        wait_idle();

        // halted: adds are ignored from here on
        set_idle(18, 18);
        queue_random(60);
        wait_idle();

        // halt survives enable writes and a zero threshold
        write_reg(REG_ENABLE, 32'd0);
        write_reg(REG_STOP_THR, 32'd0);
        queue_random(20);
        wait_idle();
        write_reg(REG_ENABLE, 32'd1);
        queue_random(40);
        wait_idle();

        if (expected_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_q.size());
            n_fail = n_fail + 1;
        end
        $display("%0d transactions in, %0d results checked: %0d counted adds, %0d queries",
                 in_acc, out_acc, n_counted, n_queries);
        $display("enable on and off, thresholds zero to all ones, %0d results while halted",
                 n_stopped);
        if (n_fail == 0) begin
            $display("count_min_sketch_counter test passed");
        end else begin
            $display("count_min_sketch_counter test failed");
        end
        $finish;
    end

endmodule
